// File: design/tpt_pkg.sv
// shared constants and types for the page table translator
package tpt_pkg;

    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;
    localparam int TLB_DEPTH   = 16;

    localparam int ADDR_W      = 16;
    localparam int PAGE_W      = 8;
    localparam int OFFSET_W    = 8;
    localparam int FRAME_W     = 8;
    localparam int USER_W      = 3;

    localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
    localparam int FCNT_W      = $clog2(FRAME_COUNT + 1);

    localparam logic [PAGE_W:0]     PAGE_LIMIT  = (PAGE_W + 1)'(PAGE_COUNT);
    localparam logic [FCNT_W-1:0]   FRAME_LIMIT = FCNT_W'(FRAME_COUNT);

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_entry;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } t_map_rd;

endpackage

// File: design/tpt_tlb_cell.sv
// one tlb slot: holds an entry, compares it, passes it on when a new entry shifts in
module tpt_tlb_cell
    import tpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  t_tlb_entry         i_entry,
    input  logic [PAGE_W-1:0]  i_page,
    output t_tlb_entry         o_entry,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame
);

    t_tlb_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_entry.valid && (r_entry.page == i_page);
    assign o_frame = o_hit ? r_entry.frame : '0;

endmodule

// File: design/tpt_page_table.sv
// page table: frame memory with registered read and per-page valid flops
module tpt_page_table
    import tpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  logic [PAGE_IDX_W-1:0] i_rd_page,
    output t_map_rd               o_rd,
    input  logic                  i_wr_en,
    input  logic [PAGE_IDX_W-1:0] i_wr_page,
    input  logic [FRAME_W-1:0]    i_wr_frame
);

    logic [FRAME_W-1:0]    r_frame_mem [PAGE_COUNT];
    logic [PAGE_COUNT-1:0] r_valid;
    t_map_rd               r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_page] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_frame_mem[i_wr_page] <= i_wr_frame;
        end
        if (i_rd_en) begin
            r_rd.frame <= r_frame_mem[i_rd_page];
            r_rd.valid <= r_valid[i_rd_page];
        end
    end

    assign o_rd = r_rd;

endmodule

// File: design/tlb_page_table_translator_unit.sv
// top level: tlb cell row, page table and result register
// word and table read are registered, then ST_LOOK loads the result when the output is free
// a new word is taken only after the last one's page table read and tlb/table update
// a pending result may sit in the output register while the next word is taken
// frames are handed out in ascending order, so a counter tracks the lowest free one
// reset (synchronous, active low) empties the tlb, page table and frame pool at once
module tlb_page_table_translator_unit
    import tpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] logical_address
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [15:0] physical_address
    output logic [USER_W-1:0] m_axis_tuser    // [0] tlb_hit, [1] page_fault, [2] no_free_frame
);

    typedef enum logic {ST_IDLE, ST_LOOK} t_state;

    t_state              r_state;
    logic [PAGE_W-1:0]   r_page;
    logic [OFFSET_W-1:0] r_offset;
    logic [FCNT_W-1:0]   r_frames_used;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [USER_W-1:0]   r_out_user;

    t_map_rd             map_rd;
    t_tlb_entry          cell_in  [TLB_DEPTH];
    t_tlb_entry          cell_out [TLB_DEPTH];
    logic                cell_hit [TLB_DEPTH];
    logic [FRAME_W-1:0]  cell_frame [TLB_DEPTH];

    logic                tlb_hit;
    logic [FRAME_W-1:0]  tlb_frame;
    logic                out_free;
    logic                finish;
    logic                in_range;
    logic                alloc;
    logic                insert;
    logic [FRAME_W-1:0]  new_frame;
    logic [FRAME_W-1:0]  use_frame;
    logic [ADDR_W-1:0]   n_addr;
    logic [USER_W-1:0]   n_user;
    t_tlb_entry          new_entry;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign finish        = (r_state == ST_LOOK) && out_free;

    // tlb row: new entry enters slot 0, the oldest falls off the far end
    assign new_entry.valid = 1'b1;
    assign new_entry.page  = r_page;
    assign new_entry.frame = use_frame;

    for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_in[g] = new_entry;
        end else begin : g_link
            assign cell_in[g] = cell_out[g-1];
        end
        tpt_tlb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (finish && insert),
            .i_entry (cell_in[g]),
            .i_page  (r_page),
            .o_entry (cell_out[g]),
            .o_hit   (cell_hit[g]),
            .o_frame (cell_frame[g])
        );
    end

    // a page is never held twice, so the matches can simply be or-ed
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = 0; i < TLB_DEPTH; i++) begin
            tlb_hit   = tlb_hit | cell_hit[i];
            tlb_frame = tlb_frame | cell_frame[i];
        end
    end

    tpt_page_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_axis_tvalid && s_axis_tready),
        .i_rd_page  (s_axis_tdata[OFFSET_W +: PAGE_IDX_W]),
        .o_rd       (map_rd),
        .i_wr_en    (finish && alloc),
        .i_wr_page  (r_page[PAGE_IDX_W-1:0]),
        .i_wr_frame (new_frame)
    );

    assign new_frame = FRAME_W'(r_frames_used);
    assign in_range  = ({1'b0, r_page} < PAGE_LIMIT);

    always_comb begin
        alloc     = 1'b0;
        insert    = 1'b0;
        use_frame = map_rd.frame;
        n_addr    = '0;
        n_user    = 3'b010;
        if (!in_range) begin
            n_user = 3'b010;
        end else if (tlb_hit) begin
            n_addr = {tlb_frame, r_offset};
            n_user = 3'b001;
        end else if (map_rd.valid) begin
            insert = 1'b1;
            n_addr = {map_rd.frame, r_offset};
            n_user = 3'b000;
        end else if (r_frames_used == FRAME_LIMIT) begin
            n_user = 3'b110;
        end else begin
            alloc     = 1'b1;
            insert    = 1'b1;
            use_frame = new_frame;
            n_addr    = {new_frame, r_offset};
            n_user    = 3'b010;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_frames_used <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (s_axis_tvalid) begin
                        r_page   <= s_axis_tdata[ADDR_W-1:OFFSET_W];
                        r_offset <= s_axis_tdata[OFFSET_W-1:0];
                        r_state  <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_addr  <= n_addr;
                        r_out_user  <= n_user;
                        r_state     <= ST_IDLE;
                        if (alloc) begin
                            r_frames_used <= r_frames_used + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_user;

endmodule

// File: design/tpt_checker.sv
// port-level checks for the page table translator, bound to the top level
module tpt_checker
    import tpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [15:0]       m_axis_tdata,
    input  logic [USER_W-1:0] m_axis_tuser
);

    // a word passes through ST_LOOK before the next is taken, so no word is taken right after another
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on back-to-back cycles");

    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && (m_axis_tuser[1] || m_axis_tuser[2])))
        else $error("tlb hit flagged together with a fault");

    a_nofree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1] && (m_axis_tdata == '0)))
        else $error("out of frames without fault or with nonzero address");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind tlb_page_table_translator_unit tpt_checker u_tpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tpt_result_checker.sv
// checker for the page table translator: predicts each translation and compares result words
module tpt_result_checker
    import tpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    input  logic              i_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [15:0] logical_address
    input  logic              i_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic [15:0]       i_m_axis_tdata,   // [15:0] physical_address
    input  logic [USER_W-1:0] i_m_axis_tuser,   // [0] tlb_hit, [1] page_fault, [2] no_free_frame
    output int                o_fail_count,
    output int                o_pending_count
);

    localparam int HIT_BIT    = 0;
    localparam int FAULT_BIT  = 1;
    localparam int NOFREE_BIT = 2;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        logic              tlb_hit;
        logic              page_fault;
        logic              no_free_frame;
    } t_translation;

    logic               map_valid  [PAGE_COUNT];
    logic [FRAME_W-1:0] map_frame  [PAGE_COUNT];
    logic               frame_used [FRAME_COUNT];
    t_tlb_entry         tlb_slots  [TLB_DEPTH];
    int                 fifo_ptr;

    t_translation       expected_translations[$];

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic t_translation predict_translation(input logic [ADDR_W-1:0] laddr);
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        t_translation        res;
        int                  found;
        page   = laddr[ADDR_W-1:OFFSET_W];
        offset = laddr[OFFSET_W-1:0];
        res    = '0;
        if (int'(page) >= PAGE_COUNT) begin
            res.page_fault = 1'b1;
            return res;
        end
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (tlb_slots[i].valid && tlb_slots[i].page == page) begin
                res.phys_addr = {tlb_slots[i].frame, offset};
                res.tlb_hit   = 1'b1;
            end
        end
        if (res.tlb_hit)
            return res;
        if (!map_valid[page]) begin
            res.page_fault = 1'b1;
            found = -1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (!frame_used[i] && found < 0)
                    found = i;
            end
            if (found < 0) begin
                res.no_free_frame = 1'b1;
                return res;
            end
            map_valid[page]   = 1'b1;
            map_frame[page]   = FRAME_W'(found);
            frame_used[found] = 1'b1;
        end
        tlb_slots[fifo_ptr] = '{valid: 1'b1, page: page, frame: map_frame[page]};
        fifo_ptr            = (fifo_ptr + 1) % TLB_DEPTH;
        res.phys_addr       = {map_frame[page], offset};
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_translation want;
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_COUNT; i++) begin
                map_valid[i] = 1'b0;
                map_frame[i] = '0;
            end
            for (int i = 0; i < FRAME_COUNT; i++)
                frame_used[i] = 1'b0;
            for (int i = 0; i < TLB_DEPTH; i++)
                tlb_slots[i] = '0;
            fifo_ptr = 0;
            expected_translations.delete();
        end else begin
            // result side first: a word taken on this edge cannot answer this edge's input
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_translations.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h/%b",
                                              i_m_axis_tdata, i_m_axis_tuser));
                end else begin
                    want = expected_translations.pop_front();
                    if (i_m_axis_tdata !== want.phys_addr)
                        report_mismatch($sformatf("physical_address %h, want %h",
                                                  i_m_axis_tdata, want.phys_addr));
                    if (i_m_axis_tuser[HIT_BIT] !== want.tlb_hit)
                        report_mismatch($sformatf("tlb_hit %b, want %b",
                                                  i_m_axis_tuser[HIT_BIT], want.tlb_hit));
                    if (i_m_axis_tuser[FAULT_BIT] !== want.page_fault)
                        report_mismatch($sformatf("page_fault %b, want %b",
                                                  i_m_axis_tuser[FAULT_BIT], want.page_fault));
                    if (i_m_axis_tuser[NOFREE_BIT] !== want.no_free_frame)
                        report_mismatch($sformatf("no_free_frame %b, want %b",
                                                  i_m_axis_tuser[NOFREE_BIT],
                                                  want.no_free_frame));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_translations.push_back(predict_translation(i_s_axis_tdata));
        end
        o_pending_count <= expected_translations.size();
    end

    final begin
        if (expected_translations.size() != 0)
            $display("%0d expected result words never arrived", expected_translations.size());
    end

endmodule

// File: dv/tb_top.sv
// testbench top for the page table translator: stimulus, handshake idling and verdict
module tb_top;
    import tpt_pkg::*;

    localparam int HOT_PAGES    = 24;
    localparam int PHASES       = 4;
    localparam int PHASE_WORDS  = 470;
    localparam int MAX_IDLE     = 13;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;

    int                fail_count;
    int                pending_count;
    logic              tx_quiet;
    logic              rx_quiet;
    logic [PAGE_W-1:0] hot_pages [HOT_PAGES];

    tlb_page_table_translator_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tpt_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #(20 * 1000000);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_word(input logic [15:0] laddr);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= laddr;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // result side: per word stall, none while rx_quiet
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [15:0] laddr;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, hits on the same page, then enough new pages to wrap the tlb
        send_word(16'h0000);
        send_word(16'h00ff);
        send_word(16'hff00);
        send_word(16'hffff);
        send_word(16'h5aa5);
        for (int p = 16'h10; p <= 16'h1d; p++)
            send_word({8'(p), 8'($urandom)});
        // evicted page: tlb miss with a table hit
        send_word(16'h0042);
        send_word(16'h10aa);
        send_word(16'hff01);
        wait_for_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_quiet = (ph == 1) || (ph == 3);
            rx_quiet = (ph == 2) || (ph == 3);
            for (int i = 0; i < HOT_PAGES; i++)
                hot_pages[i] = 8'($urandom);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                // mostly a small working set so the tlb and page table both get hit
                if ($urandom_range(0, 3) != 0)
                    laddr = {hot_pages[$urandom_range(0, HOT_PAGES - 1)], 8'($urandom)};
                else
                    laddr = 16'($urandom);
                send_word(laddr);
            end
            wait_for_results();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
